// ===== rtl/mfbp_pkg.sv =====
// Shared types and constants of the MSB-first field bit packer.
// Depends on nothing; every other file of the block imports it.
package mfbp_pkg;

   localparam int VALUE_W = 64;   // width of a field value
   localparam int WIDTH_W = 7;    // width of the field width code
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 3;    // pending bit count, 0..7
   localparam int PEND_W  = 7;    // pending bits, right aligned
   localparam int NEED_W  = 4;    // bits needed to finish a byte, 1..8

   localparam int MAX_FIELD_BITS_DEF = 64;

   // Request codes.
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_ALIGN  = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [VALUE_W-1:0]   field_value;
      logic [WIDTH_W-1:0]   field_width;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Operands of one step of the byte unit.
   typedef struct packed {
      logic              flush;
      logic [CNT_W-1:0]  cnt;
      logic [PEND_W-1:0] pend;
      logic [BYTE_W-1:0] win;    // next eight field bits, oldest in bit 7
   } step_cmd_type;

   // Outcome of one step of the byte unit.
   typedef struct packed {
      logic              emit;
      logic              last;
      logic              done;
      logic [BYTE_W-1:0] byte_out;
      logic [PEND_W-1:0] pend;
      logic [CNT_W-1:0]  cnt;
      logic [NEED_W-1:0] need;
   } step_res_type;

endpackage

// ===== rtl/mfbp_step_unit.sv =====
// Byte unit of the MSB-first field bit packer: one step completes at most one byte.
// Depends on mfbp_pkg.
module mfbp_step_unit #(
   parameter int REM_W = 7
) (
   input  mfbp_pkg::step_cmd_type cmd,
   input  logic [REM_W-1:0]       rem,
   output mfbp_pkg::step_res_type res,
   output logic [REM_W-1:0]       rem_next
);
   import mfbp_pkg::*;

   logic [NEED_W-1:0] need;
   logic [REM_W-1:0]  need_ext;
   logic [REM_W-1:0]  rem_left;
   logic [BYTE_W-1:0] pend_ext;
   logic [BYTE_W-1:0] merged;
   logic [BYTE_W-1:0] absorbed;
   logic [NEED_W-1:0] rem_small;

   always_comb begin
      need      = NEED_W'(BYTE_W) - {1'b0, cmd.cnt};
      need_ext  = REM_W'(need);
      rem_left  = rem - need_ext;
      pend_ext  = {1'b0, cmd.pend};
      merged    = (pend_ext << need) | (cmd.win >> cmd.cnt);
      rem_small = rem[NEED_W-1:0];
      absorbed  = (pend_ext << rem_small) | (cmd.win >> (NEED_W'(BYTE_W) - rem_small));

      res          = '0;
      res.need     = need;
      rem_next     = '0;
      if (cmd.flush) begin
         // Partial byte goes out with its unfilled low bits at zero.
         res.emit     = 1'b1;
         res.last     = 1'b1;
         res.done     = 1'b1;
         res.byte_out = pend_ext << need;
      end else if (rem >= need_ext) begin
         res.emit     = 1'b1;
         res.byte_out = merged;
         res.last     = (rem_left < REM_W'(BYTE_W));
         res.done     = (rem_left == '0);
         rem_next     = rem_left;
      end else begin
         // Fewer bits left than a byte needs: they become pending bits.
         res.done = 1'b1;
         res.pend = absorbed[PEND_W-1:0];
         res.cnt  = cmd.cnt + rem[CNT_W-1:0];
      end
   end

endmodule

// ===== rtl/msb_first_field_bit_packer_core.sv =====
// Top level of the MSB-first field bit packer: handshakes, sequencer and state.
// Depends on mfbp_pkg and mfbp_step_unit.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_payload_type (type, value, width)
//   rsp_      out        rsp_valid/rsp_stall  rsp_payload_type (byte, last of run)
//
// An append of w bits onto c pending bits is accepted and then takes
// ceil((c + w)/8) steps of the shared byte unit.
// An align takes one step when a partial byte is pending and none otherwise.
// Every step waits for the output register to be free, so a stalled result
// channel holds the sequencer where it is.
// Reset is synchronous and clears the pending bits, the sequencer and the output valid.
module msb_first_field_bit_packer_core #(
   parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mfbp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mfbp_pkg::rsp_payload_type rsp_payload
);
   import mfbp_pkg::*;

   // Remaining field bits fit in a counter sized for the largest field.
   localparam int REM_W = $clog2(MAX_FIELD_BITS + 1);
   localparam logic [WIDTH_W-1:0] MAX_W   = WIDTH_W'(MAX_FIELD_BITS);
   localparam logic [WIDTH_W-1:0] VALUE_WC = WIDTH_W'(VALUE_W);

   state_type state_ff, state_in;

   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               flush_ff, flush_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic               out_free;
   logic               step_go;
   logic [WIDTH_W-1:0] width_sat;
   logic               start_append;
   logic               start_flush;

   step_cmd_type       cmd;
   step_res_type       res;
   logic [REM_W-1:0]   rem_next;

   // A transaction is taken only while the sequencer is idle.
   assign req_take = req_valid && !req_stall;

   // The output register may be loaded when empty or when its byte leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step_go  = (state_ff == ST_RUN) && out_free;

   // Widths beyond the configured maximum are clipped to it.
   assign width_sat = (req_payload.field_width > MAX_W) ? MAX_W : req_payload.field_width;

   assign start_append = req_take && (req_payload.req_type == REQ_APPEND) && (width_sat != '0);
   assign start_flush  = req_take && (req_payload.req_type == REQ_ALIGN) && (cnt_ff != '0);

   // The shared unit sees the oldest unconsumed field bits at the top of val_ff.
   assign cmd.flush = flush_ff;
   assign cmd.cnt   = cnt_ff;
   assign cmd.pend  = pend_ff;
   assign cmd.win   = flush_ff ? '0 : val_ff[VALUE_W-1 -: BYTE_W];

   mfbp_step_unit #(
      .REM_W(REM_W)
   ) u_step (
      .cmd      (cmd),
      .rem      (rem_ff),
      .res      (res),
      .rem_next (rem_next)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_append || start_flush) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_go && res.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_RUN:  req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // Datapath next values.
   always_comb begin
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      flush_in     = flush_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (start_append) begin
         // Left-align the field; bits above its width fall off the top.
         val_in   = req_payload.field_value << (VALUE_WC - width_sat);
         rem_in   = REM_W'(width_sat);
         flush_in = 1'b0;
      end else if (start_flush) begin
         flush_in = 1'b1;
         rem_in   = '0;
      end

      if (step_go) begin
         pend_in = res.pend;
         cnt_in  = res.cnt;
         rem_in  = rem_next;
         val_in  = val_ff << res.need;
         if (res.done) begin
            flush_in = 1'b0;
         end
         if (res.emit) begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_byte    = res.byte_out;
            rsp_data_in.last_of_run = res.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== rtl/mfbp_checker.sv =====
// Port-level checks of the MSB-first field bit packer, bound to its top level.
// Depends on mfbp_pkg and msb_first_field_bit_packer_core.
module mfbp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input mfbp_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input mfbp_pkg::rsp_payload_type rsp_payload
);
   import mfbp_pkg::*;

   // A stalled result transaction keeps its byte and stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result transaction changed while stalled");

   // Reset leaves the output register empty.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Reset leaves the sequencer idle and ready for a request.
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request side stalled after reset");

   // While a run still owes bytes, no new request may enter.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_of_run |-> req_stall)
      else $error("request taken in the middle of a byte run");

endmodule

bind msb_first_field_bit_packer_core mfbp_checker u_mfbp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/msb_first_field_bit_packer_core_tb.sv =====
// Self-checking testbench for msb_first_field_bit_packer_core.
// Holds its own predictor of the packed byte stream and depends only on mfbp_pkg and the RTL.
module msb_first_field_bit_packer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfbp_pkg::*;

   localparam int FIELD_BITS_MAX   = MAX_FIELD_BITS_DEF;
   localparam int IDLE_PCT         = 17;      // idle cycles per hundred on each side
   localparam int LONG_HOLD_CYCLES = 250;     // one long output hold-off
   localparam int DRAIN_CYCLES     = 24;      // extra wait after the last owed byte
   localparam int LIMIT_CYCLES     = 200000;  // far above the slowest correct run

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   // Transactions waiting to be offered, filled by the stimulus process.
   req_payload_type pending_reqs[$];
   // Stream bytes the block still owes, oldest first.
   rsp_payload_type expected_stream_bytes[$];

   // Shadow copy of the partial byte that the block carries between requests.
   logic [PEND_W-1:0] shadow_bits  = '0;
   logic [CNT_W-1:0]  shadow_count = '0;

   // Idling control, written only by the stimulus process.
   logic quiet       = 1'b0;
   logic hold_wanted = 1'b0;

   // Owned by the output monitor.
   logic hold_taken     = 1'b0;
   int   hold_left      = 0;
   int   mismatch_count = 0;
   int   bytes_checked  = 0;

   // Owned by the request driver.
   int items_accepted  = 0;
   int aligns_accepted = 0;
   int cycle_count     = 0;

   msb_first_field_bit_packer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the bytes that one accepted request completes and advances the
   // shadow state. A byte is queued only once the next one is known, so that the
   // final byte of the run can carry the last flag.
   function automatic void predict_stream_bytes(req_payload_type rq);
      int unsigned    nbits;
      int unsigned    fill;
      int unsigned    aligned;
      int             bit_idx;
      logic [7:0]     acc;
      logic           have_prev;
      rsp_payload_type prev;
      have_prev = 1'b0;
      prev      = '0;
      if (rq.req_type == REQ_ALIGN) begin
         // A partial byte is flushed with zeros below the pending bits; an
         // already aligned stream produces nothing.
         if (shadow_count != '0) begin
            aligned   = int'(shadow_bits) << (8 - int'(shadow_count));
            prev      = '{out_byte: aligned[7:0], last_of_run: 1'b0};
            have_prev = 1'b1;
         end
         shadow_bits  = '0;
         shadow_count = '0;
      end else begin
         // Widths beyond the maximum saturate, and value bits at or above the
         // width never enter the stream. A zero width leaves everything as is.
         nbits = rq.field_width;
         if (nbits > FIELD_BITS_MAX)
            nbits = FIELD_BITS_MAX;
         acc  = {1'b0, shadow_bits};
         fill = shadow_count;
         for (bit_idx = int'(nbits) - 1; bit_idx >= 0; bit_idx--) begin
            acc  = {acc[6:0], rq.field_value[bit_idx]};
            fill = fill + 1;
            if (fill == 8) begin
               if (have_prev)
                  expected_stream_bytes.push_back(prev);
               prev      = '{out_byte: acc, last_of_run: 1'b0};
               have_prev = 1'b1;
               acc       = '0;
               fill      = 0;
            end
         end
         shadow_bits  = acc[6:0];
         shadow_count = fill[2:0];
      end
      if (have_prev) begin
         prev.last_of_run = 1'b1;
         expected_stream_bytes.push_back(prev);
      end
   endfunction

   // Random request. Most appends are short so that bytes straddle field
   // boundaries often; a few use zero or oversized widths.
   function automatic req_payload_type random_request();
      req_payload_type rq;
      int unsigned     pick;
      pick           = $urandom_range(99);
      rq.field_value = {$urandom, $urandom};
      rq.field_width = 7'($urandom_range(127));
      if (pick < 14) begin
         rq.req_type = REQ_ALIGN;
      end else begin
         rq.req_type = REQ_APPEND;
         if (pick < 70)
            rq.field_width = 7'($urandom_range(16, 1));
         else if (pick < 92)
            rq.field_width = 7'($urandom_range(64, 17));
      end
      case ($urandom_range(19))
         0: rq.field_value = '0;
         1: rq.field_value = '1;
         default: ;
      endcase
      return rq;
   endfunction

   task automatic queue_append(input logic [WIDTH_W-1:0] width, input logic [VALUE_W-1:0] value);
      pending_reqs.push_back('{req_type: REQ_APPEND, field_value: value, field_width: width});
   endtask

   // The width and value of an align are meaningless, so they are random.
   task automatic queue_align();
      pending_reqs.push_back('{req_type: REQ_ALIGN, field_value: {$urandom, $urandom},
                               field_width: 7'($urandom_range(127))});
   endtask

   task automatic queue_random(input int count);
      int k;
      for (k = 0; k < count; k++)
         pending_reqs.push_back(random_request());
   endtask

   // Blocks until every queued transaction has been taken by the block.
   task automatic wait_all_sent();
      while (pending_reqs.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   // Request driver. A new transaction is offered only when the previous one
   // was accepted or nothing was offered, so a stalled payload never changes.
   // The decision to idle never looks at req_stall.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d stream bytes outstanding.",
                  cycle_count, expected_stream_bytes.size());
         $display("msb_first_field_bit_packer_core test failed");
         $finish;
      end
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_stream_bytes(req_payload);
            items_accepted++;
            if (req_payload.req_type == REQ_ALIGN)
               aligns_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               req_payload <= pending_reqs.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output monitor. Every accepted byte is compared with the oldest one the
   // predictor owes. The same process also decides the stall for the next
   // cycle, including the one long hold-off that lets the block back up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stream_bytes.size() == 0) begin
               $error("Unexpected stream byte %02h (last_of_run %0b) with nothing pending.",
                      rsp_payload.out_byte, rsp_payload.last_of_run);
               mismatch_count++;
            end else begin
               if (rsp_payload.out_byte !== expected_stream_bytes[0].out_byte) begin
                  $error("Field out_byte: expected %02h, actual %02h.",
                         expected_stream_bytes[0].out_byte, rsp_payload.out_byte);
                  mismatch_count++;
               end
               if (rsp_payload.last_of_run !== expected_stream_bytes[0].last_of_run) begin
                  $error("Field last_of_run: expected %0b, actual %0b.",
                         expected_stream_bytes[0].last_of_run, rsp_payload.last_of_run);
                  mismatch_count++;
               end
               void'(expected_stream_bytes.pop_front());
            end
            bytes_checked++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int leftover;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: extreme widths and values, stray bits above the width,
      // zero and oversized widths, aligns with and without a partial byte.
      queue_append(7'd1, 64'h1);
      queue_append(7'd7, 64'h7F);                    // completes one byte exactly
      queue_align();                                 // already aligned, no output
      queue_append(7'd0, '1);                        // zero width, no effect
      queue_append(7'd3, 64'hFFFF_FFFF_FFFF_FFF5);   // only the low three bits count
      queue_align();                                 // flushes a partial byte
      queue_append(7'd64, '1);
      queue_append(7'd64, '0);
      queue_append(7'd5, 64'h15);
      queue_append(7'd64, 64'h0123_4567_89AB_CDEF);  // eight bytes from an unaligned start
      queue_append(7'd127, {$urandom, $urandom});    // saturates to the maximum width
      queue_append(7'd65, 64'hDEAD_BEEF_0BAD_F00D);
      queue_append(7'd100, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_align();
      queue_align();                                 // align right after align
      queue_append(7'd8, 64'h5A);
      queue_append(7'd7, 64'h55);
      queue_append(7'd1, '0);
      queue_append(7'd7, 64'h2A);
      queue_align();
      queue_append(7'd64, 64'h8000_0000_0000_0001);
      queue_append(7'd2, 64'h2);
      queue_append(7'd64, 64'h5555_5555_5555_5555);
      queue_align();

      // The sender pauses here until every owed byte has come out.
      wait_all_sent();
      while (expected_stream_bytes.size() != 0)
         @(negedge clock);

      // Random part, first with a long output hold-off while requests keep
      // coming, then a stretch with no idling on either side, then normal again.
      hold_wanted = 1'b1;
      queue_random(62);
      wait_all_sent();
      quiet = 1'b1;
      queue_random(62);
      wait_all_sent();
      quiet = 1'b0;
      queue_random(62);
      queue_align();
      wait_all_sent();

      while (expected_stream_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      leftover = expected_stream_bytes.size();
      if (leftover != 0)
         $error("%0d expected stream bytes never arrived.", leftover);
      $display("Run covered %0d requests (%0d aligns) and checked %0d stream bytes,",
               items_accepted, aligns_accepted, bytes_checked);
      $display("with random stalls, a %0d-cycle output hold-off and a stretch without idling.",
               LONG_HOLD_CYCLES);
      if (mismatch_count == 0 && leftover == 0)
         $display("msb_first_field_bit_packer_core test passed");
      else
         $display("msb_first_field_bit_packer_core test failed");
      $finish;
   end

endmodule

// ===== msb_first_field_bit_packer_core.f =====
rtl/mfbp_pkg.sv
rtl/mfbp_step_unit.sv
rtl/msb_first_field_bit_packer_core.sv
rtl/mfbp_checker.sv
tb/msb_first_field_bit_packer_core_tb.sv
